@@ hw/rtl/brd_pkg.sv @@
`default_nettype none
package brd_pkg;

	localparam int MAX_LINE_DEF = 2048;
	localparam int LINE_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [LINE_W-1:0] LINE_BYTES_RST = 12'd640;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORMAT_MODE  = 2'd0,
		REG_CHANNEL_SWAP = 2'd1,
		REG_LINE_BYTES   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		SWAP_NONE = 2'd0,
		SWAP_RB   = 2'd1,
		SWAP_RG   = 2'd2,
		SWAP_GB   = 2'd3
	} swap_t;

	typedef enum logic {
		FMT_BAYER  = 1'b0,
		FMT_RGB565 = 1'b1
	} fmt_t;

	// per-item scan position, carried into the window stage
	typedef struct packed {
		logic [7:0] cur;
		logic       col_odd;
		logic       col_zero;
		logic       first_row;
		logic       row_odd;
		logic       last_bayer;
		logic       last_565;
	} scan_t;

endpackage
`default_nettype wire

@@ hw/rtl/brd_line_buf.sv @@
`default_nettype none
module brd_line_buf #(
	parameter int DEPTH = brd_pkg::MAX_LINE_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [AW-1:0] addr,
	input  wire logic [7:0]    wdata,
	output logic      [7:0]    rdata_s1
);

	logic [7:0] mem [DEPTH];

	// read-first: the item sees the previous row's byte, then overwrites it
	always_ff @(posedge clk) begin
		if (en) begin
			rdata_s1 <= mem[addr];
			mem[addr] <= wdata;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/brd_scan.sv @@
`default_nettype none
module brd_scan #(
	parameter int MAX_LINE = brd_pkg::MAX_LINE_DEF,
	parameter int CW       = $clog2(MAX_LINE + 1),
	parameter int AW       = $clog2(MAX_LINE)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [7:0]           pixel_byte,
	input  wire logic                 frame_start,
	input  wire logic [CW-1:0]        len,
	input  wire logic                 s1_adv,
	output logic                      in_stall,
	output logic                      accept,
	output logic      [AW-1:0]        addr,
	output logic                      s1_valid,
	output brd_pkg::scan_t            scan_s1
);

	logic [CW-1:0] col_q;
	logic          row_odd_q;
	logic          first_row_q;
	logic          wrap;
	logic [CW-1:0] c;
	logic [CW-1:0] c_inc;
	logic [CW:0]   c_inc2;
	logic          rodd;
	logic          first;
	logic          end_line;
	brd_pkg::scan_t scan_d;

	assign in_stall = s1_valid && !s1_adv;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		wrap     = !frame_start && (col_q >= len);
		c        = (frame_start || wrap) ? '0 : col_q;
		rodd     = frame_start ? 1'b0 : (wrap ? ~row_odd_q : row_odd_q);
		first    = frame_start ? 1'b1 : (wrap ? 1'b0 : first_row_q);
		c_inc    = c + CW'(1);
		c_inc2   = {1'b0, c} + (CW+1)'(2);
		end_line = c_inc >= len;
		scan_d.cur        = pixel_byte;
		scan_d.col_odd    = c[0];
		scan_d.col_zero   = (c == '0);
		scan_d.first_row  = first;
		scan_d.row_odd    = rodd;
		scan_d.last_bayer = end_line;
		scan_d.last_565   = c_inc2 >= {1'b0, len};
	end

	assign addr = c[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_odd_q   <= 1'b0;
			first_row_q <= 1'b1;
			s1_valid    <= 1'b0;
		end else begin
			if (accept) begin
				col_q       <= end_line ? '0 : c_inc;
				row_odd_q   <= end_line ? ~rodd : rodd;
				first_row_q <= end_line ? 1'b0 : first;
				s1_valid    <= 1'b1;
			end else if (s1_adv) begin
				s1_valid    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scan_s1 <= scan_d;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/brd_pixel.sv @@
`default_nettype none
module brd_pixel (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s1_valid,
	input  wire brd_pkg::scan_t scan_s1,
	input  wire logic [7:0]     upper_s1,
	input  wire brd_pkg::fmt_t  format_mode,
	input  wire brd_pkg::swap_t channel_swap,
	input  wire logic           out_stall,
	output logic                s1_adv,
	output logic                out_valid,
	output logic      [7:0]     red,
	output logic      [7:0]     green,
	output logic      [7:0]     blue,
	output logic                line_end
);

	logic [7:0] left_q;
	logic [7:0] ul_q;
	logic [7:0] held_q;
	logic [7:0] r;
	logic [7:0] g;
	logic [7:0] b;
	logic [7:0] ro;
	logic [7:0] go;
	logic [7:0] bo;
	logic       has_res;
	logic       le;
	logic       win_row_odd;
	logic       win_col_odd;
	logic       fire;
	logic       emit;

	assign s1_adv = !out_valid || !out_stall;
	assign fire   = s1_valid && s1_adv;

	always_comb begin
		win_row_odd = !scan_s1.row_odd;
		win_col_odd = !scan_s1.col_odd;
		if (format_mode == brd_pkg::FMT_RGB565) begin
			r       = {held_q[7:3], 3'b000};
			g       = {held_q[2:0], scan_s1.cur[7:5], 2'b00};
			b       = {scan_s1.cur[4:0], 3'b000};
			has_res = scan_s1.col_odd;
			le      = scan_s1.last_565;
		end else begin
			has_res = !scan_s1.first_row && !scan_s1.col_zero;
			le      = scan_s1.last_bayer;
			if (!win_row_odd && !win_col_odd) begin
				r = ul_q;
				g = {1'b0, upper_s1[7:1]} + {1'b0, left_q[7:1]};
				b = scan_s1.cur;
			end else if (!win_row_odd) begin
				r = upper_s1;
				g = {1'b0, ul_q[7:1]} + {1'b0, scan_s1.cur[7:1]};
				b = left_q;
			end else if (!win_col_odd) begin
				r = left_q;
				g = {1'b0, ul_q[7:1]} + {1'b0, scan_s1.cur[7:1]};
				b = upper_s1;
			end else begin
				r = scan_s1.cur;
				g = {1'b0, upper_s1[7:1]} + {1'b0, left_q[7:1]};
				b = ul_q;
			end
		end
		ro = r;
		go = g;
		bo = b;
		case (channel_swap)
			brd_pkg::SWAP_RB: begin
				ro = b;
				bo = r;
			end
			brd_pkg::SWAP_RG: begin
				ro = g;
				go = r;
			end
			brd_pkg::SWAP_GB: begin
				go = b;
				bo = g;
			end
			default: begin
			end
		endcase
	end

	assign emit = fire && has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			ul_q      <= '0;
			held_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (fire) begin
				left_q <= scan_s1.cur;
				ul_q   <= upper_s1;
				if (format_mode == brd_pkg::FMT_RGB565 && !scan_s1.col_odd) begin
					held_q <= scan_s1.cur;
				end
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			red      <= ro;
			green    <= go;
			blue     <= bo;
			line_end <= le;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/bayer_rggb_demosaic_2x2.sv @@
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+-----------------------------------
// input     | in        | in_valid / in_stall | pixel_byte, frame_start
// output    | out       | out_valid/out_stall | red, green, blue, line_end
// config    | in        | cfg_we              | cfg_index, cfg_data
//
// One item per cycle unless stalled; results pass the window and output registers.
// The line buffer is one RAM, read and written at the same column on acceptance.
// Reset clears counters and valids; line buffer contents stay undefined until written.
// out_stall holds a valid output register and, if the window stage is full, raises in_stall.
`default_nettype none
module bayer_rggb_demosaic_2x2 #(
	parameter int MAX_LINE = brd_pkg::MAX_LINE_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     pixel_byte,
	input  wire logic                           frame_start,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [7:0]                     red,
	output logic      [7:0]                     green,
	output logic      [7:0]                     blue,
	output logic                                line_end,
	input  wire logic                           cfg_we,
	input  wire logic [brd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [brd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_LINE + 1);
	localparam int AW = $clog2(MAX_LINE);
	localparam int LW = (CW > brd_pkg::LINE_W) ? CW : brd_pkg::LINE_W;

	brd_pkg::fmt_t                 format_mode_q;
	brd_pkg::swap_t                channel_swap_q;
	logic [brd_pkg::LINE_W-1:0]    line_bytes_q;
	logic [LW-1:0]                 lb_ext;
	logic [CW-1:0]                 len;
	logic                          accept;
	logic [AW-1:0]                 addr;
	logic                          s1_valid;
	logic                          s1_adv;
	brd_pkg::scan_t                scan_s1;
	logic [7:0]                    upper_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q  <= brd_pkg::FMT_BAYER;
			channel_swap_q <= brd_pkg::SWAP_NONE;
			line_bytes_q   <= brd_pkg::LINE_BYTES_RST;
		end else if (cfg_we) begin
			case (brd_pkg::reg_idx_t'(cfg_index))
				brd_pkg::REG_FORMAT_MODE:  format_mode_q  <= brd_pkg::fmt_t'(cfg_data[0]);
				brd_pkg::REG_CHANNEL_SWAP: channel_swap_q <= brd_pkg::swap_t'(cfg_data[1:0]);
				brd_pkg::REG_LINE_BYTES:   line_bytes_q   <= cfg_data[brd_pkg::LINE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// line length clamped to [2, MAX_LINE]
	always_comb begin
		lb_ext = LW'(line_bytes_q);
		if (lb_ext < LW'(2)) begin
			len = CW'(2);
		end else if (lb_ext > LW'(MAX_LINE)) begin
			len = CW'(MAX_LINE);
		end else begin
			len = lb_ext[CW-1:0];
		end
	end

	brd_scan #(
		.MAX_LINE (MAX_LINE),
		.CW       (CW),
		.AW       (AW)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.pixel_byte  (pixel_byte),
		.frame_start (frame_start),
		.len         (len),
		.s1_adv      (s1_adv),
		.in_stall    (in_stall),
		.accept      (accept),
		.addr        (addr),
		.s1_valid    (s1_valid),
		.scan_s1     (scan_s1)
	);

	brd_line_buf #(
		.DEPTH (MAX_LINE),
		.AW    (AW)
	) u_line_buf (
		.clk      (clk),
		.en       (accept),
		.addr     (addr),
		.wdata    (pixel_byte),
		.rdata_s1 (upper_s1)
	);

	brd_pixel u_pixel (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid),
		.scan_s1      (scan_s1),
		.upper_s1     (upper_s1),
		.format_mode  (format_mode_q),
		.channel_swap (channel_swap_q),
		.out_stall    (out_stall),
		.s1_adv       (s1_adv),
		.out_valid    (out_valid),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.line_end     (line_end)
	);

endmodule
`default_nettype wire

@@ tb/sv/bayer_rggb_demosaic_2x2_test.sv @@
module bayer_rggb_demosaic_2x2_test;

	localparam int MAX_LINE = brd_pkg::MAX_LINE_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 1000;
	localparam logic [7:0] DIR_BYTES [30] = '{
		8'h00, 8'hff, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h55, 8'haa, 8'h0f, 8'hf0,
		8'hff, 8'h00, 8'h33, 8'hcc, 8'hff, 8'hff, 8'h00, 8'h01, 8'h80, 8'hff,
		8'hff, 8'h00, 8'h00, 8'hff, 8'h12, 8'h34, 8'hf8, 8'h07, 8'h07, 8'he0
	};

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       le;
	} pixel_t;

	class demosaic_tracker;
		brd_pkg::fmt_t              fmt;
		brd_pkg::swap_t             swap;
		logic [brd_pkg::LINE_W-1:0] line_bytes;
		logic [7:0]                 row_mem [MAX_LINE];
		logic [7:0]                 left_px;
		logic [7:0]                 up_left_px;
		logic [7:0]                 hi_held;
		int                         col;
		bit                         row_odd;
		bit                         first_row;
		pixel_t                     expected_pixels [$];
		int                         errors;
		int                         checked;
		int                         fed_items;

		function new();
			fmt = brd_pkg::FMT_BAYER;
			swap = brd_pkg::SWAP_NONE;
			line_bytes = brd_pkg::LINE_BYTES_RST;
			foreach (row_mem[i]) row_mem[i] = 8'h00;
			left_px = 8'h00;
			up_left_px = 8'h00;
			hi_held = 8'h00;
			col = 0;
			row_odd = 0;
			first_row = 1;
			errors = 0;
			checked = 0;
			fed_items = 0;
		endfunction

		function void write_reg(brd_pkg::reg_idx_t idx, logic [brd_pkg::CFG_DATA_W-1:0] v);
			case (idx)
				brd_pkg::REG_FORMAT_MODE: fmt = brd_pkg::fmt_t'(v[0]);
				brd_pkg::REG_CHANNEL_SWAP: swap = brd_pkg::swap_t'(v[1:0]);
				brd_pkg::REG_LINE_BYTES: line_bytes = v[brd_pkg::LINE_W-1:0];
				default: ;
			endcase
		endfunction

		function void next_line();
			col = 0;
			row_odd = !row_odd;
			first_row = 0;
		endfunction

		function void take_byte(logic [7:0] cur, logic fs);
			int len;
			int c;
			logic [7:0] up, lf, ul, r, g, b;
			logic le;
			bit produce, win_row_odd, win_col_odd;
			pixel_t px;
			fed_items++;
			len = line_bytes;
			if (len < 2) len = 2;
			if (len > MAX_LINE) len = MAX_LINE;
			if (fs) begin
				col = 0;
				row_odd = 0;
				first_row = 1;
			end else if (col >= len) begin
				next_line();
			end
			c = col;
			up = row_mem[c];
			lf = left_px;
			ul = up_left_px;
			produce = 0;
			if (fmt == brd_pkg::FMT_RGB565) begin
				if (c % 2 == 1) begin
					r = {hi_held[7:3], 3'b000};
					g = {hi_held[2:0], cur[7:5], 2'b00};
					b = {cur[4:0], 3'b000};
					le = (c + 2 >= len);
					produce = 1;
				end else begin
					hi_held = cur;
				end
			end else if (!first_row && c >= 1) begin
				// window top-left sits one row up and one column left
				win_row_odd = !row_odd;
				win_col_odd = (c % 2 == 0);
				if (!win_row_odd && !win_col_odd) begin
					r = ul;
					g = (up >> 1) + (lf >> 1);
					b = cur;
				end else if (!win_row_odd) begin
					r = up;
					g = (ul >> 1) + (cur >> 1);
					b = lf;
				end else if (!win_col_odd) begin
					r = lf;
					g = (ul >> 1) + (cur >> 1);
					b = up;
				end else begin
					r = cur;
					g = (up >> 1) + (lf >> 1);
					b = ul;
				end
				le = (c == len - 1);
				produce = 1;
			end
			if (produce) begin
				px.r = r;
				px.g = g;
				px.b = b;
				px.le = le;
				case (swap)
					brd_pkg::SWAP_RB: begin
						px.r = b;
						px.b = r;
					end
					brd_pkg::SWAP_RG: begin
						px.r = g;
						px.g = r;
					end
					brd_pkg::SWAP_GB: begin
						px.g = b;
						px.b = g;
					end
					default: ;
				endcase
				expected_pixels.push_back(px);
			end
			row_mem[c] = cur;
			up_left_px = up;
			left_px = cur;
			col = c + 1;
			if (col >= len) next_line();
		endfunction

		function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic le);
			pixel_t e;
			if (expected_pixels.size() == 0) begin
				$error("unexpected pixel: red %0d green %0d blue %0d line_end %0d",
					r, g, b, le);
				errors++;
				return;
			end
			e = expected_pixels.pop_front();
			checked++;
			if (r !== e.r) begin
				$error("red: expected %0d, got %0d", e.r, r);
				errors++;
			end
			if (g !== e.g) begin
				$error("green: expected %0d, got %0d", e.g, g);
				errors++;
			end
			if (b !== e.b) begin
				$error("blue: expected %0d, got %0d", e.b, b);
				errors++;
			end
			if (le !== e.le) begin
				$error("line_end: expected %0d, got %0d", e.le, le);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 0;
	logic                           arst_n = 0;
	logic                           in_valid = 0;
	logic                           in_stall;
	logic [7:0]                     pixel_byte = 0;
	logic                           frame_start = 0;
	logic                           out_valid;
	logic                           out_stall = 0;
	logic [7:0]                     red;
	logic [7:0]                     green;
	logic [7:0]                     blue;
	logic                           line_end;
	logic                           cfg_we = 0;
	logic [brd_pkg::CFG_IDX_W-1:0]  cfg_index = 0;
	logic [brd_pkg::CFG_DATA_W-1:0] cfg_data = 0;

	demosaic_tracker tracker;
	int cycles = 0;
	int hold_left = 0;
	int burst_left = 0;
	int reg_writes = 0;
	bit idle_on = 1;

	bayer_rggb_demosaic_2x2 dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_byte(pixel_byte),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.line_end(line_end),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = !clk;
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("bayer_rggb_demosaic_2x2: mismatch");
		$finish;
	end

	// receiver: long hold when asked, random stall bursts otherwise while idle_on is set
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else if (burst_left > 0) begin
				burst_left--;
				out_stall <= 1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(0, 4);
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_pixel(red, green, blue, line_end);
	end

	task automatic write_reg(input brd_pkg::reg_idx_t idx,
		input logic [brd_pkg::CFG_DATA_W-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		tracker.write_reg(idx, v);
		reg_writes++;
	endtask

	task automatic feed_byte(input logic [7:0] b, input logic fs);
		int gap;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		pixel_byte <= b;
		frame_start <= fs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.take_byte(b, fs);
	endtask

	task automatic settle();
		in_valid <= 0;
		@(posedge clk);
		while (tracker.expected_pixels.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic configure(input brd_pkg::fmt_t f, input brd_pkg::swap_t s,
		input logic [brd_pkg::CFG_DATA_W-1:0] len);
		write_reg(brd_pkg::REG_FORMAT_MODE, brd_pkg::CFG_DATA_W'(f));
		write_reg(brd_pkg::REG_CHANNEL_SWAP, brd_pkg::CFG_DATA_W'(s));
		write_reg(brd_pkg::REG_LINE_BYTES, len);
	endtask

	initial begin : stimulus
		int n;
		int rand_items;
		int phase_no;
		tracker = new();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// bayer, 3 full rows of 4 then 2 bytes into the next
		configure(brd_pkg::FMT_BAYER, brd_pkg::SWAP_NONE, 12'd4);
		for (int i = 0; i < 14; i++) feed_byte(DIR_BYTES[i], i == 0);
		settle();
		// shorter line while mid-row, length below the floor
		configure(brd_pkg::FMT_BAYER, brd_pkg::SWAP_RB, 12'd0);
		for (int i = 14; i < 19; i++) feed_byte(DIR_BYTES[i], 0);
		settle();
		// 565 with an odd line, unpaired byte dropped
		configure(brd_pkg::FMT_RGB565, brd_pkg::SWAP_RG, 12'd5);
		for (int i = 19; i < 26; i++) feed_byte(DIR_BYTES[i], i == 19);
		settle();
		configure(brd_pkg::FMT_RGB565, brd_pkg::SWAP_GB, 12'd1);
		for (int i = 26; i < 30; i++) feed_byte(DIR_BYTES[i], 0);
		settle();

		// long lines: above the buffer size, then exactly the buffer size
		configure(brd_pkg::FMT_RGB565, brd_pkg::SWAP_GB, 12'd4095);
		for (int i = 0; i < 80; i++)
			feed_byte(8'($urandom_range(0, 255)), i == 0);
		settle();
		configure(brd_pkg::FMT_RGB565, brd_pkg::SWAP_RB, 12'd2048);
		for (int i = 0; i < 80; i++)
			feed_byte(8'($urandom_range(0, 255)), i == 0);
		settle();

		rand_items = 0;
		phase_no = 0;
		while (rand_items < RANDOM_ITEMS) begin
			if (rand_items >= RANDOM_ITEMS - 200) idle_on = 0;
			configure(($urandom_range(0, 2) == 0) ? brd_pkg::FMT_RGB565 : brd_pkg::FMT_BAYER,
				brd_pkg::swap_t'($urandom_range(0, 3)),
				brd_pkg::CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
					$urandom_range(0, 1) : $urandom_range(2, 24)));
			n = $urandom_range(30, 120);
			if (phase_no == 2) begin
				n = 200;
				hold_left = 300;
			end
			for (int i = 0; i < n; i++)
				feed_byte(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 63) == 0);
			rand_items += n;
			phase_no++;
			settle();
		end

		$display("%0d bytes fed, %0d pixels checked, %0d register writes",
			tracker.fed_items, tracker.checked, reg_writes);
		$display("bayer and rgb565, all swaps, lengths clamped low and high, odd lines");
		if (tracker.errors == 0)
			$display("bayer_rggb_demosaic_2x2: match");
		else
			$display("bayer_rggb_demosaic_2x2: mismatch");
		$finish;
	end

endmodule
